[rtl/core/lci_pkg.sv]
// ----------------------------------------------------------------------------
// lci_pkg: shared types and constants for the line/cylinder crossing block
// Field widths, beat structs, register indexes and the context record that
// travels down the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package lci_pkg;

    localparam int POS_W  = 32;           // Q16.16 positions and lengths
    localparam int DIR_W  = 16;           // Q2.14 direction components
    localparam int LEN_W  = 32;
    localparam int RAD_W  = 31;           // radius and min_step
    localparam int CFG_W  = 32;           // config write data
    localparam int DOT_W  = 48;           // |pos_x*dir_x + pos_y*dir_y|
    localparam int T2_W   = 32;           // dir_x^2 + dir_y^2
    localparam int N_W    = T2_W / 2;     // transverse norm
    localparam int PROJ_W = 32;           // clamped projection magnitude
    localparam int SQ_W   = 64;           // discriminant
    localparam int S_W    = SQ_W / 2;     // its root
    localparam int STEP_W = 47;           // 3-D step, and flt scaled by 2^14
    localparam int FRAC_D = 14;           // fraction bits of a direction

    localparam logic [PROJ_W-1:0]       PROJ_CAP = '1;
    localparam logic signed [LEN_W-1:0] LEN_MAX  = {1'b0, {(LEN_W-1){1'b1}}};

    typedef enum logic [1:0] {
        CFG_RADIUS   = 2'd0,
        CFG_LOW_Z    = 2'd1,
        CFG_HIGH_Z   = 2'd2,
        CFG_MIN_STEP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic signed [LEN_W-1:0] path_length;
    } t_trk_in;

    typedef struct packed {
        logic                    hit;
        logic signed [LEN_W-1:0] new_path_length;
    } t_trk_out;

    // per-track context carried alongside the sqrt and divide pipes
    typedef struct packed {
        logic signed [POS_W-1:0]  pos_z;
        logic signed [DIR_W-1:0]  dir_z;
        logic signed [LEN_W-1:0]  path_length;
        logic [DOT_W-1:0]         dot_mag;
        logic                     dot_neg;
        logic [SQ_W-1:0]          pmag2;
        logic [N_W-1:0]           n;
        logic signed [PROJ_W:0]   proj;
        logic                     miss;
    } t_ctx;

endpackage

[rtl/core/lci_stream_if.sv]
// ----------------------------------------------------------------------------
// lci_stream_if: valid/ready stream channel
// One beat moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface lci_stream_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/lci_sqrt.sv]
// ----------------------------------------------------------------------------
// lci_sqrt: pipelined integer square root
// Floor root of an IN_W-bit radicand, one root bit per stage, IN_W/2 stages.
// A side record rides along with each operand.
// ----------------------------------------------------------------------------
module lci_sqrt #(
    parameter int  IN_W   = 32,
    parameter type T_SIDE = logic
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_rad,
    input  T_SIDE             i_side,
    output logic              o_valid,
    output logic [IN_W/2-1:0] o_root,
    output T_SIDE             o_side
);
    localparam int H  = IN_W / 2;
    localparam int RW = H + 2;

    logic            r_valid [H];
    logic [IN_W-1:0] r_rad   [H];
    logic [RW-1:0]   r_rem   [H];
    logic [H-1:0]    r_root  [H];
    T_SIDE           r_side  [H];

    for (genvar k = 0; k < H; k++) begin : g_stage
        logic            a_valid;
        logic [IN_W-1:0] a_rad;
        logic [RW-1:0]   a_rem;
        logic [H-1:0]    a_root;
        T_SIDE           a_side;
        logic [RW+1:0]   cur_t;
        logic [RW+1:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign a_valid = i_valid;
            assign a_rad   = i_rad;
            assign a_rem   = '0;
            assign a_root  = '0;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_valid = r_valid[k-1];
            assign a_rad   = r_rad[k-1];
            assign a_rem   = r_rem[k-1];
            assign a_root  = r_root[k-1];
            assign a_side  = r_side[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign cur_t = {a_rem, a_rad[IN_W-1 -: 2]};
        assign trial = {2'b00, a_root, 2'b01};
        assign ge    = cur_t >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {a_rad[IN_W-3:0], 2'b00};
                r_rem[k]  <= ge ? RW'(cur_t - trial) : RW'(cur_t);
                r_root[k] <= {a_root[H-2:0], ge};
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_valid[H-1];
    assign o_root  = r_root[H-1];
    assign o_side  = r_side[H-1];
endmodule

[rtl/core/lci_div.sv]
// ----------------------------------------------------------------------------
// lci_div: pipelined unsigned restoring divider
// Quotient of an NUM_W-bit numerator by a DEN_W-bit divisor, one quotient bit
// per stage, NUM_W stages. A side record rides along with each operand.
// ----------------------------------------------------------------------------
module lci_div #(
    parameter int  NUM_W  = 48,
    parameter int  DEN_W  = 16,
    parameter type T_SIDE = logic
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  T_SIDE            i_side,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output T_SIDE            o_side
);
    logic             r_valid [NUM_W];
    logic [NUM_W-1:0] r_wq    [NUM_W];   // remaining numerator bits / quotient
    logic [DEN_W-1:0] r_rem   [NUM_W];
    logic [DEN_W-1:0] r_den   [NUM_W];
    T_SIDE            r_side  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             a_valid;
        logic [NUM_W-1:0] a_wq;
        logic [DEN_W-1:0] a_rem;
        logic [DEN_W-1:0] a_den;
        T_SIDE            a_side;
        logic [DEN_W:0]   cur_t;
        logic [DEN_W:0]   den_e;
        logic             ge;

        if (k == 0) begin : g_first
            assign a_valid = i_valid;
            assign a_wq    = i_num;
            assign a_rem   = '0;
            assign a_den   = i_den;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_valid = r_valid[k-1];
            assign a_wq    = r_wq[k-1];
            assign a_rem   = r_rem[k-1];
            assign a_den   = r_den[k-1];
            assign a_side  = r_side[k-1];
        end

        // shift in the next numerator bit and subtract when it fits
        assign cur_t = {a_rem, a_wq[NUM_W-1]};
        assign den_e = {1'b0, a_den};
        assign ge    = cur_t >= den_e;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_wq[k]   <= {a_wq[NUM_W-2:0], ge};
                r_rem[k]  <= ge ? DEN_W'(cur_t - den_e) : DEN_W'(cur_t);
                r_den[k]  <= a_den;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quo   = r_wq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];
endmodule

[rtl/core/line_cylinder_intersection.sv]
// ----------------------------------------------------------------------------
// line_cylinder_intersection: next crossing of a straight track with a
// z-axis cylinder
// Input channel i_trk carries a track beat (point, direction, path length);
// output channel o_res carries one result beat per track: hit flag and the
// new path length (input length on a miss, saturated on a hit).
// Config: radius, low_z, high_z, min_step through i_cfg_we/idx/data; write
// only while no track is in flight.
// Pipeline: accepted input beat to result beat runs through the chain of
// pipelined units: 16-stage norm sqrt, 48-stage projection divide,
// 32-stage discriminant sqrt, 47-stage step divide, plus 8 arithmetic stages.
// Throughput: one track per cycle; a new beat is taken every cycle the
// output is free or being drained.
// Reset: clears all valid bits and the config registers (all zero).
// Stall: when o_res.ready is low with a result held, the whole pipeline
// freezes and i_trk.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module line_cylinder_intersection (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    lci_stream_if.sink              i_trk,
    lci_stream_if.source            o_res,
    input  logic                    i_cfg_we,
    input  lci_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [lci_pkg::CFG_W-1:0] i_cfg_data
);
    import lci_pkg::*;

    // ---------------- configuration ----------------
    logic [RAD_W-1:0]        r_radius;
    logic signed [POS_W-1:0] r_low_z;
    logic signed [POS_W-1:0] r_high_z;
    logic [RAD_W-1:0]        r_min_step;
    logic [2*RAD_W-1:0]      r_rad2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= '0;
            r_low_z    <= '0;
            r_high_z   <= '0;
            r_min_step <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                CFG_LOW_Z:    r_low_z    <= i_cfg_data;
                CFG_HIGH_Z:   r_high_z   <= i_cfg_data;
                CFG_MIN_STEP: r_min_step <= i_cfg_data[RAD_W-1:0];
            endcase
        end
    end

    // radius squared, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_rad2 <= r_radius * r_radius;
    end

    // ---------------- global advance ----------------
    logic r9_valid;
    logic en;
    assign en          = !r9_valid || o_res.ready;
    assign i_trk.ready = en;

    // ---------------- stage 1: products ----------------
    logic                    r1_valid;
    logic signed [DOT_W-1:0] r1_pxdx, r1_pydy;
    logic [T2_W-2:0]         r1_dx2, r1_dy2;
    logic [SQ_W-1:0]         r1_ax2, r1_ay2;
    t_ctx                    r1_ctx;

    logic signed [DOT_W-1:0] pxdx, pydy;
    logic signed [T2_W-1:0]  dx2, dy2;
    logic [POS_W-1:0]        ax, ay;
    logic [SQ_W-1:0]         ax2, ay2;
    t_ctx                    n1_ctx;

    assign pxdx = i_trk.data.pos_x * i_trk.data.dir_x;
    assign pydy = i_trk.data.pos_y * i_trk.data.dir_y;
    assign dx2  = i_trk.data.dir_x * i_trk.data.dir_x;
    assign dy2  = i_trk.data.dir_y * i_trk.data.dir_y;
    assign ax   = i_trk.data.pos_x[POS_W-1] ? POS_W'(-i_trk.data.pos_x) : i_trk.data.pos_x;
    assign ay   = i_trk.data.pos_y[POS_W-1] ? POS_W'(-i_trk.data.pos_y) : i_trk.data.pos_y;
    assign ax2  = ax * ax;
    assign ay2  = ay * ay;

    always_comb begin
        n1_ctx             = '0;
        n1_ctx.pos_z       = i_trk.data.pos_z;
        n1_ctx.dir_z       = i_trk.data.dir_z;
        n1_ctx.path_length = i_trk.data.path_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_trk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pxdx <= pxdx;
            r1_pydy <= pydy;
            r1_dx2  <= dx2[T2_W-2:0];
            r1_dy2  <= dy2[T2_W-2:0];
            r1_ax2  <= ax2;
            r1_ay2  <= ay2;
            r1_ctx  <= n1_ctx;
        end
    end

    // ---------------- stage 2: sums ----------------
    logic              r2_valid;
    logic [T2_W-1:0]   r2_t2;
    t_ctx              r2_ctx;

    logic signed [DOT_W:0] dot, dot_n;
    logic [T2_W-1:0]       t2;
    t_ctx                  n2_ctx;

    assign dot   = r1_pxdx + r1_pydy;
    assign dot_n = -dot;
    assign t2    = r1_dx2 + r1_dy2;

    always_comb begin
        n2_ctx         = r1_ctx;
        n2_ctx.dot_neg = dot[DOT_W];
        n2_ctx.dot_mag = dot[DOT_W] ? dot_n[DOT_W-1:0] : dot[DOT_W-1:0];
        n2_ctx.pmag2   = r1_ax2 + r1_ay2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t2  <= t2;
            r2_ctx <= n2_ctx;
        end
    end

    // ---------------- transverse norm n = floor(sqrt(t2)) ----------------
    logic           sn_valid;
    logic [N_W-1:0] sn_root;
    t_ctx           sn_ctx;
    t_ctx           dv_ctx;

    lci_sqrt #(.IN_W(T2_W), .T_SIDE(t_ctx)) u_sqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_rad   (r2_t2),
        .i_side  (r2_ctx),
        .o_valid (sn_valid),
        .o_root  (sn_root),
        .o_side  (sn_ctx)
    );

    // zero transverse direction is a miss
    always_comb begin
        dv_ctx      = sn_ctx;
        dv_ctx.n    = sn_root;
        dv_ctx.miss = (sn_root == '0);
    end

    // ---------------- |proj| = |dot| / n ----------------
    logic             dp_valid;
    logic [DOT_W-1:0] dp_quo;
    t_ctx             dp_ctx;

    lci_div #(.NUM_W(DOT_W), .DEN_W(N_W), .T_SIDE(t_ctx)) u_div_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sn_valid),
        .i_num   (sn_ctx.dot_mag),
        .i_den   (sn_root),
        .i_side  (dv_ctx),
        .o_valid (dp_valid),
        .o_quo   (dp_quo),
        .o_side  (dp_ctx)
    );

    // ---------------- stage 4: clamp and sign ----------------
    logic              r4_valid;
    logic [PROJ_W-1:0] r4_aproj;
    t_ctx              r4_ctx;

    logic [PROJ_W-1:0] aproj;
    logic [PROJ_W:0]   aproj_e;
    t_ctx              n4_ctx;

    assign aproj   = (dp_quo > DOT_W'(PROJ_CAP)) ? PROJ_CAP : dp_quo[PROJ_W-1:0];
    assign aproj_e = {1'b0, aproj};

    always_comb begin
        n4_ctx      = dp_ctx;
        n4_ctx.proj = dp_ctx.dot_neg ? -aproj_e : aproj_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= dp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_aproj <= aproj;
            r4_ctx   <= n4_ctx;
        end
    end

    // ---------------- stage 5: proj^2 ----------------
    logic            r5_valid;
    logic [SQ_W-1:0] r5_proj2;
    t_ctx            r5_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_proj2 <= r4_aproj * r4_aproj;
            r5_ctx   <= r4_ctx;
        end
    end

    // ---------------- stage 6: discriminant, saturated ----------------
    logic            r6_valid;
    logic [SQ_W-1:0] r6_sq;
    t_ctx            r6_ctx;

    logic signed [SQ_W+1:0] disc;
    logic                   disc_pos;
    t_ctx                   n6_ctx;

    assign disc = $signed({2'b00, r5_proj2}) + $signed({4'b0000, r_rad2})
                - $signed({2'b00, r5_ctx.pmag2});
    assign disc_pos = disc > 0;

    always_comb begin
        n6_ctx      = r5_ctx;
        n6_ctx.miss = r5_ctx.miss || !disc_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_sq  <= (disc[SQ_W+1:SQ_W] != 2'b00) ? '1 : disc[SQ_W-1:0];
            r6_ctx <= n6_ctx;
        end
    end

    // ---------------- s = floor(sqrt(sq)) ----------------
    logic           ss_valid;
    logic [S_W-1:0] ss_root;
    t_ctx           ss_ctx;

    lci_sqrt #(.IN_W(SQ_W), .T_SIDE(t_ctx)) u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_valid),
        .i_rad   (r6_sq),
        .i_side  (r6_ctx),
        .o_valid (ss_valid),
        .o_root  (ss_root),
        .o_side  (ss_ctx)
    );

    // ---------------- stage 7: nearer positive root ----------------
    logic              r7_valid;
    logic [STEP_W-1:0] r7_num;
    t_ctx              r7_ctx;

    logic signed [PROJ_W+2:0] proj_e, mp, sv, flt;
    t_ctx                     n7_ctx;

    assign proj_e = ss_ctx.proj;
    assign mp     = -proj_e;
    assign sv     = $signed({3'b000, ss_root});
    assign flt    = (mp > sv) ? mp - sv : mp + sv;

    always_comb begin
        n7_ctx      = ss_ctx;
        n7_ctx.miss = ss_ctx.miss || !(flt > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (en) begin
            r7_valid <= ss_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_num <= {flt[STEP_W-FRAC_D-1:0], {FRAC_D{1'b0}}};
            r7_ctx <= n7_ctx;
        end
    end

    // ---------------- step = flt * 2^14 / n ----------------
    logic              sd_valid;
    logic [STEP_W-1:0] sd_quo;
    t_ctx              sd_ctx;

    lci_div #(.NUM_W(STEP_W), .DEN_W(N_W), .T_SIDE(t_ctx)) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_valid),
        .i_num   (r7_num),
        .i_den   (r7_ctx.n),
        .i_side  (r7_ctx),
        .o_valid (sd_valid),
        .o_quo   (sd_quo),
        .o_side  (sd_ctx)
    );

    // ---------------- stage 8: |dir_z| * step ----------------
    logic                    r8_valid;
    logic [STEP_W-1:0]       r8_step;
    logic [STEP_W+DIR_W-1:0] r8_prod;
    t_ctx                    r8_ctx;

    logic signed [DIR_W-1:0] dz_n;
    logic [DIR_W-1:0]        adz;

    assign dz_n = -sd_ctx.dir_z;
    assign adz  = sd_ctx.dir_z[DIR_W-1] ? dz_n : sd_ctx.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (en) begin
            r8_valid <= sd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_step <= sd_quo;
            r8_prod <= adz * sd_quo;
            r8_ctx  <= sd_ctx;
        end
    end

    // ---------------- stage 9: z window, min step, new length ----------------
    t_trk_out r9_out;

    localparam int ZOFF_W = STEP_W + DIR_W - FRAC_D;

    logic [ZOFF_W-1:0]        zoff;
    logic signed [ZOFF_W+1:0] pz_e, zoff_e, z;
    logic signed [STEP_W+1:0] len_e, newlen;
    logic                     hit;
    t_trk_out                 n9_out;

    // truncate toward zero: shift the magnitude, then apply the sign
    assign zoff   = r8_prod[STEP_W+DIR_W-1:FRAC_D];
    assign pz_e   = r8_ctx.pos_z;
    assign zoff_e = $signed({2'b00, zoff});
    assign z      = r8_ctx.dir_z[DIR_W-1] ? pz_e - zoff_e : pz_e + zoff_e;
    assign len_e  = r8_ctx.path_length;
    assign newlen = len_e + $signed({1'b0, r8_step});

    assign hit = !r8_ctx.miss && (r8_step > r_min_step)
              && (z > r_low_z) && (z < r_high_z);

    always_comb begin
        n9_out.hit = hit;
        if (!hit) begin
            n9_out.new_path_length = r8_ctx.path_length;
        end else if (newlen > LEN_MAX) begin
            n9_out.new_path_length = LEN_MAX;
        end else begin
            n9_out.new_path_length = newlen[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else if (en) begin
            r9_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_out <= n9_out;
        end
    end

    assign o_res.valid = r9_valid;
    assign o_res.data  = r9_out;
endmodule

[rtl/core/lci_checker.sv]
// ----------------------------------------------------------------------------
// lci_checker: port-level checks for line_cylinder_intersection
// Watches the stream handshakes and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module lci_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input lci_pkg::t_trk_out   i_out_data
);
    import lci_pkg::*;

    // input side opens exactly when the result register is free or draining
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output stall");

    // no result beat in the first cycle out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !i_out_valid)
        else $error("result beat present after reset");

    // a stalled result beat holds and keeps its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result beat changed");

    // while stalled, no input beat can slip in
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !(i_in_valid && i_in_ready))
        else $error("input beat taken during output stall");
endmodule

bind line_cylinder_intersection lci_checker u_lci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_trk.valid),
    .i_in_ready  (i_trk.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

[bench/lci_tb_pkg.sv]
// ----------------------------------------------------------------------------
// lci_tb_pkg: bench settings
// Register index used by the stimulus in tb.
// ----------------------------------------------------------------------------
package lci_tb_pkg;

    import lci_pkg::*;

    // index 3 aliases CFG_MIN_STEP, so a write to it sets min_step
    localparam logic [1:0] CFG_NONE = 2'd3;

endpackage

[bench/lci_crossing_checker.sv]
// ----------------------------------------------------------------------------
// lci_crossing_checker: crossing predictor and result scoreboard
// Mirrors the config writes, computes the expected hit and path length for
// each accepted track beat and compares each result beat in order.
// ----------------------------------------------------------------------------
module lci_crossing_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_trk_valid,
    input  logic                      i_trk_ready,
    input  lci_pkg::t_trk_in          i_trk_data,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  lci_pkg::t_trk_out         i_res_data,
    input  logic                      i_cfg_we,
    input  lci_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [lci_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lci_pkg::*;

    logic [RAD_W-1:0]        radius_q;
    logic signed [POS_W-1:0] low_z_q;
    logic signed [POS_W-1:0] high_z_q;
    logic [RAD_W-1:0]        min_step_q;
    t_trk_out                expected_q[$];

    // bit-by-bit integer square root
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_trk_out predict_crossing(input t_trk_in t);
        longint          px, py, pz, dx, dy, dz, plen, n, proj, s, mp, flt, stp, z, nl;
        logic [63:0]     t2, aproj, proj2, ax, ay, pmag2, rad2, sq, d;
        bit              real_root;
        t_trk_out        r;
        px = t.pos_x; py = t.pos_y; pz = t.pos_z;
        dx = t.dir_x; dy = t.dir_y; dz = t.dir_z;
        plen = t.path_length;
        r.hit = 1'b0;
        r.new_path_length = t.path_length;
        t2 = dx * dx + dy * dy;
        if (t2 == 0) return r;
        n = root_floor(t2);
        proj = (px * dx + py * dy) / n;
        if (proj > 64'sd4294967295) proj = 64'sd4294967295;
        if (proj < -64'sd4294967295) proj = -64'sd4294967295;
        aproj = proj < 0 ? -proj : proj;
        proj2 = aproj * aproj;
        ax = px < 0 ? -px : px;
        ay = py < 0 ? -py : py;
        pmag2 = ax * ax + ay * ay;
        rad2 = 64'(radius_q) * 64'(radius_q);
        real_root = 0;
        sq = 0;
        if (pmag2 >= rad2) begin
            d = pmag2 - rad2;
            if (proj2 > d) begin
                sq = proj2 - d;
                real_root = 1;
            end
        end else begin
            d = rad2 - pmag2;
            sq = (proj2 > ~64'd0 - d) ? ~64'd0 : proj2 + d;
            real_root = 1;
        end
        if (!real_root) return r;
        s = root_floor(sq);
        mp = -proj;
        flt = (mp > s) ? mp - s : mp + s;
        if (flt <= 0) return r;
        stp = (flt * 16384) / n;
        z = pz + (dz * stp) / 16384;
        if (stp > longint'(min_step_q) && z > longint'(low_z_q) && z < longint'(high_z_q)) begin
            nl = plen + stp;
            if (nl > 64'sd2147483647) nl = 64'sd2147483647;
            r.hit = 1'b1;
            r.new_path_length = nl[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_trk_out want;
        if (!i_rst_n) begin
            radius_q <= '0;
            low_z_q <= '0;
            high_z_q <= '0;
            min_step_q <= '0;
        end else begin
            // config mirror
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:   radius_q <= i_cfg_data[RAD_W-1:0];
                    CFG_LOW_Z:    low_z_q <= i_cfg_data;
                    CFG_HIGH_Z:   high_z_q <= i_cfg_data;
                    CFG_MIN_STEP: min_step_q <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_trk_valid && i_trk_ready)
                expected_q.push_back(predict_crossing(i_trk_data));
            // result compare
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res_data.hit !== want.hit)
                        report_mismatch("hit", i_res_data.hit, want.hit);
                    if (i_res_data.new_path_length !== want.new_path_length)
                        report_mismatch("new_path_length", i_res_data.new_path_length,
                                        want.new_path_length);
                end
            end
        end
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: line/cylinder crossing bench
// Drives directed and random tracks through several register settings with
// random gaps and output stalls; the checker scores every result beat.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lci_pkg::*;
    import lci_tb_pkg::*;

    localparam int LATENCY  = 151;
    localparam int MAX_CYC  = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    t_cfg_idx          cfg_idx = CFG_RADIUS;
    logic [CFG_W-1:0]  cfg_data = '0;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;

    lci_stream_if #(.T_DATA(t_trk_in))  trk_if();
    lci_stream_if #(.T_DATA(t_trk_out)) res_if();

    initial begin
        trk_if.valid = 1'b0;
        trk_if.data = '0;
        res_if.ready = 1'b0;
    end

    line_cylinder_intersection i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_trk(trk_if.sink), .o_res(res_if.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    lci_crossing_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_trk_valid(trk_if.valid), .i_trk_ready(trk_if.ready), .i_trk_data(trk_if.data),
        .i_res_valid(res_if.valid), .i_res_ready(res_if.ready), .i_res_data(res_if.data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("tb failed");
            $finish;
        end
    end

    // gap length: over half none, most others short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // receiver stalls
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = gap_len();
            if (g != 0) begin
                res_if.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_track(input t_trk_in t);
        int g;
        g = gap_len();
        if (g != 0) begin
            trk_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        trk_if.valid <= 1'b1;
        trk_if.data <= t;
        @(posedge i_clk);
        while (!trk_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        trk_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [DIR_W-1:0] rand_dir();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'sd16384;
        if (p == 1) return -16'sd16384;
        if (p == 2) return 16'sd0;
        if (p == 3) return DIR_W'($urandom);
        return DIR_W'($signed($urandom_range(32768)) - 16384);
    endfunction

    // position: mostly near the cylinder so crossings occur
    function automatic logic signed [POS_W-1:0] rand_pos(input int span);
        if ($urandom_range(7) == 0) return $urandom;
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_trk_in rand_track(input int span);
        t_trk_in t;
        t.pos_x = rand_pos(span);
        t.pos_y = rand_pos(span);
        t.pos_z = rand_pos(span);
        t.dir_x = rand_dir();
        t.dir_y = rand_dir();
        t.dir_z = rand_dir();
        t.path_length = ($urandom_range(9) == 0) ? $urandom
                        : $signed($urandom_range(32'h00100000));
        return t;
    endfunction

    function automatic t_trk_in mk(input int x, y, z, input int dx, dy, dz, input int len);
        t_trk_in t;
        t.pos_x = x; t.pos_y = y; t.pos_z = z;
        t.dir_x = DIR_W'(dx); t.dir_y = DIR_W'(dy); t.dir_z = DIR_W'(dz);
        t.path_length = len;
        return t;
    endfunction

    initial begin
        int span;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: radius 10, window +-100, min_step 0
        write_reg(CFG_RADIUS, 32'd10 << 16);
        write_reg(CFG_LOW_Z, -(32'd100 << 16));
        write_reg(CFG_HIGH_Z, 32'd100 << 16);
        write_reg(CFG_MIN_STEP, 32'd0);
        write_reg(t_cfg_idx'(CFG_NONE), 32'd1 << 16);
        write_reg(CFG_MIN_STEP, 32'd0);
        send_track(mk(0, 0, 0, 16384, 0, 0, 0));                 // from inside
        send_track(mk(-(20 << 16), 0, 0, 16384, 0, 0, 100));     // from outside
        send_track(mk(20 << 16, 0, 0, 16384, 0, 0, 5));          // root behind
        send_track(mk(0, 20 << 16, 0, 16384, 0, 0, 7));          // no real root
        send_track(mk(0, 0, 0, 0, 0, 16384, 9));                 // zero transverse
        send_track(mk(0, 0, 0, 8192, 0, 8192, 0));               // non-unit direction
        send_track(mk(0, 0, 99 << 16, 11585, 0, 11585, 0));      // z beyond window
        send_track(mk(0, 0, 0, 16384, 0, 0, 32'h7FFFFFF0));      // path saturation
        send_track(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      -16384, 16384, -16384, 32'h80000000));
        send_track(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      16384, -16384, 16384, 32'h7FFFFFFF));
        send_track(mk(1, -1, 0, -1, 1, -1, -1));
        send_track(mk(0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0));
        drain();
        write_reg(CFG_MIN_STEP, 32'd15 << 16);                   // step too short
        send_track(mk(0, 0, 0, 16384, 0, 0, 0));
        send_track(mk(-(20 << 16), 0, 0, 16384, 0, 0, 0));
        drain();
        write_reg(CFG_LOW_Z, 32'd5 << 16);                       // empty window
        write_reg(CFG_HIGH_Z, 32'd5 << 16);
        send_track(mk(0, 0, 5 << 16, 16384, 0, 0, 0));
        drain();

        // random phases across settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_RADIUS, 32'h7FFFFFFF); write_reg(CFG_LOW_Z, 32'h80000000);
                    write_reg(CFG_HIGH_Z, 32'h7FFFFFFF); write_reg(CFG_MIN_STEP, 32'd0);
                    span = 32'h7FFFFFFF;
                end
                1: begin
                    write_reg(CFG_RADIUS, 32'd0); write_reg(CFG_MIN_STEP, 32'h7FFFFFFF);
                    span = 32'h00100000;
                end
                default: begin
                    write_reg(CFG_RADIUS, $urandom_range(32'h00400000, 32'h00010000));
                    write_reg(CFG_LOW_Z, -$signed($urandom_range(32'h01000000)));
                    write_reg(CFG_HIGH_Z, $urandom_range(32'h01000000));
                    write_reg(CFG_MIN_STEP, $urandom_range(32'h00080000));
                    span = 32'h00800000;
                end
            endcase
            repeat (90) send_track(rand_track(span));
            drain();
        end

        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
